FILE: rtl/core/mqlf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linked multi-queue FIFO package
// Field widths, status and operation codes, the stored record layout and the
// command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package mqlf_pkg;

	localparam int QID_W    = 2;
	localparam int DATA_W   = 16;
	localparam int STATUS_W = 2;
	localparam int REC_W    = 2 * DATA_W;

	localparam logic OP_ENQ = 1'b0;
	localparam logic OP_DEQ = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Score sits in the upper half of a stored record, class number in the lower.
	typedef struct packed {
		logic [DATA_W-1:0] score;
		logic [DATA_W-1:0] class_number;
	} record_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic link;
		logic load_out;
	} mqlf_cmd_t;

	typedef struct packed {
		logic link_needed;
	} mqlf_stat_t;

endpackage

FILE: rtl/core/mqlf_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one queue operation.
// ----------------------------------------------------------------------------
interface mqlf_req_if;
	import mqlf_pkg::*;

	logic              valid;
	logic              ready;
	logic              op;
	logic [QID_W-1:0]  queue_id;
	logic [DATA_W-1:0] class_number;
	logic [DATA_W-1:0] score;

	modport source (output valid, output op, output queue_id, output class_number,
		output score, input ready);
	modport sink (input valid, input op, input queue_id, input class_number,
		input score, output ready);

endinterface

FILE: rtl/core/mqlf_resp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries the status and record of one operation.
// ----------------------------------------------------------------------------
interface mqlf_resp_if;
	import mqlf_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [DATA_W-1:0]   class_out;
	logic [DATA_W-1:0]   score_out;

	modport source (output valid, output status, output class_out, output score_out,
		input ready);
	modport sink (input valid, input status, input class_out, input score_out,
		output ready);

endinterface

FILE: rtl/core/mqlf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mqlf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/core/mqlf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linked multi-queue FIFO controller
// Sequences one request through capture, execute, link when needed and
// respond, and owns the valid flag of the response register.
// ----------------------------------------------------------------------------
module mqlf_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	output logic                resp_valid,
	input  logic                resp_ready,
	output mqlf_pkg::mqlf_cmd_t cmd,
	input  mqlf_pkg::mqlf_stat_t stat
);
	import mqlf_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EXEC = 4'b0010,
		S_LINK = 4'b0100,
		S_RESP = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   resp_valid_q;
	logic   out_free;

	assign out_free   = !resp_valid_q || resp_ready;
	assign req_ready  = (state_q == S_IDLE);
	assign resp_valid = resp_valid_q;

	assign cmd.capture  = req_valid && req_ready;
	assign cmd.exec     = (state_q == S_EXEC);
	assign cmd.link     = (state_q == S_LINK);
	assign cmd.load_out = (state_q == S_RESP) && out_free;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.capture) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = stat.link_needed ? S_LINK : S_RESP;
			end
			S_LINK: begin
				state_d = S_RESP;
			end
			S_RESP: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			resp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				resp_valid_q <= 1'b1;
			end else if (resp_ready) begin
				resp_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/core/mqlf_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linked multi-queue FIFO datapath
// Queue pointers, free list, node stores and the response register.
// ----------------------------------------------------------------------------
module mqlf_dp #(
	parameter int NUM_QUEUES = 3,
	parameter int POOL_DEPTH = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  mqlf_pkg::mqlf_cmd_t             cmd,
	output mqlf_pkg::mqlf_stat_t            stat,
	input  logic                            req_op,
	input  logic [mqlf_pkg::QID_W-1:0]      req_queue_id,
	input  logic [mqlf_pkg::DATA_W-1:0]     req_class_number,
	input  logic [mqlf_pkg::DATA_W-1:0]     req_score,
	output logic [mqlf_pkg::STATUS_W-1:0]   status,
	output logic [mqlf_pkg::DATA_W-1:0]     class_out,
	output logic [mqlf_pkg::DATA_W-1:0]     score_out
);
	import mqlf_pkg::*;

	localparam int PTR_W  = $clog2(POOL_DEPTH);
	localparam int CNT_W  = $clog2(POOL_DEPTH + 1);
	localparam int QIDX_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam logic [PTR_W-1:0] LastNode  = PTR_W'(POOL_DEPTH - 1);
	localparam logic [CNT_W-1:0] FullCount = CNT_W'(POOL_DEPTH);

	logic [PTR_W-1:0]  queue_head_q     [NUM_QUEUES];
	logic [PTR_W-1:0]  queue_tail_q     [NUM_QUEUES];
	logic              queue_nonempty_q [NUM_QUEUES];
	logic [PTR_W-1:0]  free_head_q;
	logic [CNT_W-1:0]  free_count_q;
	// Nodes at or above this mark have never been allocated; their free-list
	// successor is taken as the next index, so no clearing pass is needed.
	logic [CNT_W-1:0]  fill_q;

	logic              op_q;
	logic              qvalid_q;
	logic [QIDX_W-1:0] qidx_q;
	record_t           rec_q;

	status_t           res_status_q;
	record_t           res_data_q;
	status_t           out_status_q;
	record_t           out_data_q;
	logic [PTR_W-1:0]  link_addr_q;
	logic [PTR_W-1:0]  link_node_q;

	logic              qvalid_in;
	logic [QIDX_W-1:0] qidx_in;
	logic [PTR_W-1:0]  rec_raddr;
	logic [PTR_W-1:0]  link_raddr;
	logic [REC_W-1:0]  rec_rdata;
	logic [PTR_W-1:0]  link_rdata;
	logic              rec_we;
	logic              link_we;
	logic [PTR_W-1:0]  link_waddr;
	logic [PTR_W-1:0]  link_wdata;

	logic              cur_nonempty;
	logic [PTR_W-1:0]  cur_head;
	logic [PTR_W-1:0]  cur_tail;
	logic              enq_ok;
	logic              deq_ok;
	logic              fresh;
	logic [PTR_W-1:0]  succ;
	logic [PTR_W-1:0]  free_next;

	// Request side: read addresses are presented in the capture cycle.
	assign qvalid_in  = (32'(req_queue_id) < NUM_QUEUES);
	assign qidx_in    = qvalid_in ? QIDX_W'(req_queue_id) : '0;
	assign rec_raddr  = queue_head_q[qidx_in];
	assign link_raddr = (req_op == OP_DEQ) ? queue_head_q[qidx_in] : free_head_q;

	// Execute cycle decisions.
	assign cur_nonempty = queue_nonempty_q[qidx_q];
	assign cur_head     = queue_head_q[qidx_q];
	assign cur_tail     = queue_tail_q[qidx_q];
	assign enq_ok       = (op_q == OP_ENQ) && qvalid_q && (free_count_q != '0);
	assign deq_ok       = (op_q == OP_DEQ) && qvalid_q && cur_nonempty;
	assign fresh        = (CNT_W'(free_head_q) >= fill_q);
	assign succ         = (free_head_q == LastNode) ? '0 : free_head_q + PTR_W'(1);
	assign free_next    = fresh ? succ : link_rdata;

	assign stat.link_needed = enq_ok && cur_nonempty;

	assign rec_we     = cmd.exec && enq_ok;
	assign link_we    = (cmd.exec && (enq_ok || deq_ok)) || cmd.link;
	assign link_waddr = cmd.link ? link_addr_q : (enq_ok ? free_head_q : cur_head);
	assign link_wdata = cmd.link ? link_node_q : (enq_ok ? '0 : free_head_q);

	mqlf_ram #(
		.WIDTH(REC_W),
		.DEPTH(POOL_DEPTH)
	) u_rec_ram (
		.clk   (clk),
		.we    (rec_we),
		.waddr (free_head_q),
		.wdata (rec_q),
		.re    (cmd.capture),
		.raddr (rec_raddr),
		.rdata (rec_rdata)
	);

	mqlf_ram #(
		.WIDTH(PTR_W),
		.DEPTH(POOL_DEPTH)
	) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.re    (cmd.capture),
		.raddr (link_raddr),
		.rdata (link_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q              <= req_op;
			qvalid_q          <= qvalid_in;
			qidx_q            <= qidx_in;
			rec_q.class_number <= req_class_number;
			rec_q.score        <= req_score;
		end
		if (cmd.exec) begin
			link_addr_q <= cur_tail;
			link_node_q <= free_head_q;
			if (op_q == OP_ENQ) begin
				res_status_q <= enq_ok ? ST_OK : ST_FULL;
			end else begin
				res_status_q <= deq_ok ? ST_OK : ST_EMPTY;
			end
			res_data_q <= deq_ok ? record_t'(rec_rdata) : '0;
		end
		if (cmd.load_out) begin
			out_status_q <= res_status_q;
			out_data_q   <= res_data_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_QUEUES; i++) begin
				queue_head_q[i]     <= '0;
				queue_tail_q[i]     <= '0;
				queue_nonempty_q[i] <= 1'b0;
			end
			free_head_q  <= '0;
			free_count_q <= FullCount;
			fill_q       <= '0;
		end else if (cmd.exec) begin
			if (enq_ok) begin
				free_head_q  <= free_next;
				free_count_q <= free_count_q - CNT_W'(1);
				if (fresh) begin
					fill_q <= fill_q + CNT_W'(1);
				end
				if (!cur_nonempty) begin
					queue_head_q[qidx_q] <= free_head_q;
				end
				queue_tail_q[qidx_q]     <= free_head_q;
				queue_nonempty_q[qidx_q] <= 1'b1;
			end else if (deq_ok) begin
				if (cur_head == cur_tail) begin
					queue_nonempty_q[qidx_q] <= 1'b0;
				end else begin
					queue_head_q[qidx_q] <= link_rdata;
				end
				free_head_q <= cur_head;
				if (free_count_q != FullCount) begin
					free_count_q <= free_count_q + CNT_W'(1);
				end
			end
		end
	end

	assign status    = out_status_q;
	assign class_out = out_data_q.class_number;
	assign score_out = out_data_q.score;

endmodule

FILE: rtl/core/multi_queue_linked_fifo_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linked multi-queue FIFO core
// Several FIFO queues share one pool of nodes; each request enqueues a record
// onto a queue or dequeues the oldest record from it, with one response each.
// ----------------------------------------------------------------------------
// One request is in work at a time. From acceptance to a loaded response it
// goes through capture and node store read, execute and respond, with a link
// step between execute and respond for an enqueue onto a non-empty queue,
// because the link store has a single write port and such an enqueue writes
// two links. A response waits in its own register, so the next request is
// taken while it is still unread; the block stalls only if that register
// is still full when the next response is ready. No clearing pass is needed
// after reset: a fill mark tells which nodes still follow the index chain.
module multi_queue_linked_fifo_core #(
	parameter int NUM_QUEUES = 3,
	parameter int POOL_DEPTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	mqlf_req_if.sink          req,
	mqlf_resp_if.source       resp
);
	import mqlf_pkg::*;

	mqlf_cmd_t  cmd;
	mqlf_stat_t stat;

	mqlf_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req.valid),
		.req_ready  (req.ready),
		.resp_valid (resp.valid),
		.resp_ready (resp.ready),
		.cmd        (cmd),
		.stat       (stat)
	);

	mqlf_dp #(
		.NUM_QUEUES(NUM_QUEUES),
		.POOL_DEPTH(POOL_DEPTH)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.req_op           (req.op),
		.req_queue_id     (req.queue_id),
		.req_class_number (req.class_number),
		.req_score        (req.score),
		.status           (resp.status),
		.class_out        (resp.class_out),
		.score_out        (resp.score_out)
	);

endmodule

FILE: rtl/core/mqlf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linked multi-queue FIFO checker
// Port-level properties of the core, attached to every instance by bind.
// ----------------------------------------------------------------------------
module mqlf_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            req_valid,
	input logic                            req_ready,
	input logic                            resp_valid,
	input logic                            resp_ready,
	input logic [mqlf_pkg::STATUS_W-1:0]   resp_status,
	input logic [mqlf_pkg::DATA_W-1:0]     class_out,
	input logic [mqlf_pkg::DATA_W-1:0]     score_out
);
	import mqlf_pkg::*;

	// Requests accepted whose response has not yet been taken.
	logic [1:0] pending_q;
	logic       req_acc;
	logic       resp_acc;

	assign req_acc  = req_valid && req_ready;
	assign resp_acc = resp_valid && resp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 2'(req_acc) - 2'(resp_acc);
		end
	end

	a_resp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		resp_valid && !resp_ready |=> resp_valid && $stable(resp_status)
			&& $stable(class_out) && $stable(score_out))
		else $error("response changed while stalled");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		resp_valid && (resp_status != ST_OK) |-> (class_out == '0) && (score_out == '0))
		else $error("failed request returned nonzero record");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		resp_valid |-> (pending_q != 2'd0))
		else $error("response without an outstanding request");

	a_one_ahead: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |-> (pending_q <= 2'd1))
		else $error("request accepted with two already outstanding");

endmodule

bind multi_queue_linked_fifo_core mqlf_checker u_mqlf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.resp_valid  (resp.valid),
	.resp_ready  (resp.ready),
	.resp_status (resp.status),
	.class_out   (resp.class_out),
	.score_out   (resp.score_out)
);

FILE: tb/multi_queue_linked_fifo_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Linked multi-queue FIFO core testbench
// Drives enqueue and dequeue requests against all queues and an absent queue,
// predicts each response with an in-bench copy of the shared node pool, and
// checks the responses in order under random stalls on both channels.
// ----------------------------------------------------------------------------
module multi_queue_linked_fifo_core_test;
	import mqlf_pkg::*;

	localparam int NUM_QUEUES = 3;
	localparam int POOL_DEPTH = 64;
	localparam int NODE_W     = $clog2(POOL_DEPTH);
	localparam int RANDOM_REQUESTS = 700;
	localparam int LONG_HOLD_CYCLES = 64;

	typedef logic [NODE_W-1:0] node_t;

	typedef struct packed {
		status_t           status;
		logic [DATA_W-1:0] class_out;
		logic [DATA_W-1:0] score_out;
	} response_t;

	// Keeps its own copy of the node pool and queues the responses it expects.
	class queue_pool_predictor;
		record_t     node_rec [POOL_DEPTH];
		node_t       node_link [POOL_DEPTH];
		node_t       head_ptr [NUM_QUEUES];
		node_t       tail_ptr [NUM_QUEUES];
		bit          occupied [NUM_QUEUES];
		node_t       free_ptr;
		int unsigned free_nodes;
		response_t   pending_responses[$];
		int unsigned mismatches;
		int unsigned n_stored, n_returned, n_empty, n_refused;

		function new();
			for (int i = 0; i < POOL_DEPTH; i++) begin
				node_rec[i]  = '0;
				node_link[i] = node_t'(i + 1);
			end
			for (int q = 0; q < NUM_QUEUES; q++) begin
				head_ptr[q] = '0;
				tail_ptr[q] = '0;
				occupied[q] = 1'b0;
			end
			free_ptr   = '0;
			free_nodes = POOL_DEPTH;
			mismatches = 0;
			n_stored   = 0;
			n_returned = 0;
			n_empty    = 0;
			n_refused  = 0;
		endfunction

		function void note_request(logic op, logic [QID_W-1:0] qid,
				logic [DATA_W-1:0] cls, logic [DATA_W-1:0] scr);
			response_t rsp;
			node_t     n;
			bit        known_queue;
			known_queue = (qid < NUM_QUEUES);
			rsp = '{status: ST_OK, class_out: '0, score_out: '0};
			if (op == OP_ENQ) begin
				if (!known_queue || free_nodes == 0) begin
					rsp.status = ST_FULL;
					n_refused++;
				end else begin
					n = free_ptr;
					free_ptr = node_link[n];
					free_nodes--;
					node_rec[n] = '{score: scr, class_number: cls};
					node_link[n] = '0;
					if (occupied[qid])
						node_link[tail_ptr[qid]] = n;
					else
						head_ptr[qid] = n;
					tail_ptr[qid] = n;
					occupied[qid] = 1'b1;
					n_stored++;
				end
			end else begin
				if (!known_queue || !occupied[qid]) begin
					rsp.status = ST_EMPTY;
					n_empty++;
				end else begin
					n = head_ptr[qid];
					rsp.class_out = node_rec[n].class_number;
					rsp.score_out = node_rec[n].score;
					if (n == tail_ptr[qid])
						occupied[qid] = 1'b0;
					else
						head_ptr[qid] = node_link[n];
					node_link[n] = free_ptr;
					free_ptr = n;
					if (free_nodes < POOL_DEPTH)
						free_nodes++;
					n_returned++;
				end
			end
			pending_responses.push_back(rsp);
		endfunction

		function void check_response(logic [STATUS_W-1:0] st, logic [DATA_W-1:0] cls,
				logic [DATA_W-1:0] scr);
			response_t want;
			if (pending_responses.size() == 0) begin
				$error("response with no request outstanding: status %0d", st);
				mismatches++;
				return;
			end
			want = pending_responses.pop_front();
			if (st !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, st);
				mismatches++;
			end
			if (cls !== want.class_out) begin
				$error("class_out: expected %0h, got %0h", want.class_out, cls);
				mismatches++;
			end
			if (scr !== want.score_out) begin
				$error("score_out: expected %0h, got %0h", want.score_out, scr);
				mismatches++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	mqlf_req_if  req_ch ();
	mqlf_resp_if resp_ch ();

	multi_queue_linked_fifo_core #(
		.NUM_QUEUES(NUM_QUEUES),
		.POOL_DEPTH(POOL_DEPTH)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.resp   (resp_ch)
	);

	queue_pool_predictor predictor = new();

	bit          quiet_phase = 1'b0;
	bit          long_hold_done = 1'b0;
	int unsigned responses_seen = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// Mostly back-to-back, sometimes a short gap, now and then a long pause; always back-to-back in a quiet phase.
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (quiet_phase)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic idle_request(int unsigned n);
		@(negedge clk);
		req_ch.valid        <= 1'b0;
		req_ch.op           <= 1'($urandom);
		req_ch.queue_id     <= QID_W'($urandom);
		req_ch.class_number <= DATA_W'($urandom);
		req_ch.score        <= DATA_W'($urandom);
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic send_request(logic op, logic [QID_W-1:0] qid,
			logic [DATA_W-1:0] cls, logic [DATA_W-1:0] scr);
		@(negedge clk);
		req_ch.valid        <= 1'b1;
		req_ch.op           <= op;
		req_ch.queue_id     <= qid;
		req_ch.class_number <= cls;
		req_ch.score        <= scr;
		do
			@(posedge clk);
		while (!req_ch.ready);
		predictor.note_request(op, qid, cls, scr);
	endtask

	task automatic send_random_request(int unsigned enq_percent);
		logic              op;
		logic [QID_W-1:0]  qid;
		logic [DATA_W-1:0] cls;
		logic [DATA_W-1:0] scr;
		int unsigned       gap;
		op  = ($urandom_range(0, 99) < enq_percent) ? OP_ENQ : OP_DEQ;
		qid = ($urandom_range(0, 19) == 0) ? QID_W'(NUM_QUEUES) :
			QID_W'($urandom_range(0, NUM_QUEUES - 1));
		case ($urandom_range(0, 9))
			0: cls = '0;
			1: cls = '1;
			default: cls = DATA_W'($urandom);
		endcase
		case ($urandom_range(0, 9))
			0: scr = '0;
			1: scr = '1;
			default: scr = DATA_W'($urandom);
		endcase
		gap = pick_gap();
		if (gap != 0)
			idle_request(gap);
		send_request(op, qid, cls, scr);
	endtask

	// Response receiver: random stalls, plus one long hold-off once traffic is flowing
	// so that the response register fills and the request side backs up.
	initial begin
		int unsigned gap;
		resp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (!long_hold_done && responses_seen >= 150) begin
				resp_ch.ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES - 1) @(negedge clk);
				long_hold_done = 1'b1;
			end else begin
				gap = pick_gap();
				if (gap != 0) begin
					resp_ch.ready <= 1'b0;
					repeat (gap - 1) @(negedge clk);
				end else begin
					resp_ch.ready <= 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && resp_ch.valid && resp_ch.ready) begin
			predictor.check_response(resp_ch.status, resp_ch.class_out, resp_ch.score_out);
			responses_seen++;
		end
	end

	initial begin
		int unsigned sent;
		int unsigned seg_len;
		int unsigned enq_percent;
		arst_n              = 1'b0;
		req_ch.valid        = 1'b0;
		req_ch.op           = OP_ENQ;
		req_ch.queue_id     = '0;
		req_ch.class_number = '0;
		req_ch.score        = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty dequeues, the absent queue, extreme records, FIFO order.
		send_request(OP_DEQ, 2'd0, 16'h0000, 16'h0000);
		send_request(OP_DEQ, 2'd1, 16'hFFFF, 16'hFFFF);
		send_request(OP_DEQ, 2'd2, 16'h1234, 16'h5678);
		send_request(OP_DEQ, QID_W'(NUM_QUEUES), 16'h0000, 16'h0000);
		send_request(OP_ENQ, QID_W'(NUM_QUEUES), 16'hFFFF, 16'hFFFF);
		send_request(OP_ENQ, 2'd0, 16'h0000, 16'h0000);
		send_request(OP_ENQ, 2'd0, 16'hFFFF, 16'hFFFF);
		send_request(OP_ENQ, 2'd1, 16'hA5A5, 16'h5A5A);
		send_request(OP_ENQ, 2'd0, 16'h8000, 16'h0001);
		send_request(OP_ENQ, 2'd2, 16'h0001, 16'h8000);
		send_request(OP_ENQ, 2'd1, 16'h00FF, 16'hFF00);
		send_request(OP_DEQ, 2'd0, 16'hFFFF, 16'hFFFF);
		send_request(OP_DEQ, 2'd0, 16'h0000, 16'h0000);
		send_request(OP_DEQ, 2'd0, 16'hFFFF, 16'h0000);
		send_request(OP_DEQ, 2'd0, 16'h0000, 16'h0000);
		send_request(OP_DEQ, 2'd2, 16'h0000, 16'h0000);
		send_request(OP_DEQ, 2'd2, 16'h0000, 16'h0000);
		send_request(OP_ENQ, 2'd2, 16'hC3C3, 16'h3C3C);
		send_request(OP_DEQ, 2'd1, 16'h0000, 16'h0000);
		send_request(OP_DEQ, QID_W'(NUM_QUEUES), 16'hFFFF, 16'hFFFF);

		// Random: segments that lean toward filling, draining or mixing the pool.
		// The first one fills it far enough to see refused enqueues.
		sent = 0;
		while (sent < RANDOM_REQUESTS) begin
			if (sent == 0) begin
				seg_len     = 90;
				enq_percent = 95;
			end else begin
				seg_len = $urandom_range(20, 80);
				case ($urandom_range(0, 2))
					0: enq_percent = 90;
					1: enq_percent = 15;
					default: enq_percent = 55;
				endcase
			end
			quiet_phase = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < seg_len && sent < RANDOM_REQUESTS; i++) begin
				send_random_request(enq_percent);
				sent++;
			end
		end
		quiet_phase = 1'b0;

		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (predictor.pending_responses.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Checked %0d responses: %0d records stored, %0d returned,",
			responses_seen, predictor.n_stored, predictor.n_returned);
		$display("%0d dequeues found their queue empty, %0d enqueues were refused.",
			predictor.n_empty, predictor.n_refused);
		if (predictor.mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: multi_queue_linked_fifo_core.f
rtl/core/mqlf_pkg.sv
rtl/core/mqlf_req_if.sv
rtl/core/mqlf_resp_if.sv
rtl/core/mqlf_ram.sv
rtl/core/mqlf_ctrl.sv
rtl/core/mqlf_dp.sv
rtl/core/multi_queue_linked_fifo_core.sv
rtl/core/mqlf_checker.sv
tb/multi_queue_linked_fifo_core_test.sv
